// ===== hw/rtl/rfid_tag_presence_tracker_core_defines.svh =====
// assertion macros shared by the tracker rtl
`ifndef RFID_TAG_PRESENCE_TRACKER_CORE_DEFINES_SVH
`define RFID_TAG_PRESENCE_TRACKER_CORE_DEFINES_SVH

// same-cycle implication
`define RTPT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rtpt: same-cycle check failed");

// next-cycle implication
`define RTPT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rtpt: next-cycle check failed");

`endif

// ===== hw/rtl/rtpt_pkg.sv =====
package rtpt_pkg;

   localparam int TABLE_ENTRIES = 32;
   localparam int SLOT_BITS     = $clog2(TABLE_ENTRIES);
   localparam int CNT_BITS      = $clog2(TABLE_ENTRIES + 1);
   localparam int ID_BITS       = 16;
   localparam int THR_BITS      = 8;

   typedef logic [SLOT_BITS-1:0] slot_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;
   typedef logic [ID_BITS-1:0]   id_type;
   typedef logic [THR_BITS-1:0]  thr_type;
   typedef logic [2:0]           req_code_type;
   typedef logic [1:0]           evt_code_type;
   typedef logic [2:0]           sts_code_type;

   localparam thr_type THR_RESET = 8'd3;

   localparam req_code_type REQ_READ    = 3'd0;
   localparam req_code_type REQ_SWEEP   = 3'd1;
   localparam req_code_type REQ_ADD     = 3'd2;
   localparam req_code_type REQ_DEL_ID  = 3'd3;
   localparam req_code_type REQ_DEL_TAG = 3'd4;

   localparam evt_code_type EVT_ACK     = 2'd0;
   localparam evt_code_type EVT_MISSING = 2'd1;
   localparam evt_code_type EVT_FOUND   = 2'd2;
   localparam evt_code_type EVT_DONE    = 2'd3;

   localparam sts_code_type STS_OK        = 3'd0;
   localparam sts_code_type STS_DUPLICATE = 3'd1;
   localparam sts_code_type STS_FULL      = 3'd2;
   localparam sts_code_type STS_NOT_FOUND = 3'd3;
   localparam sts_code_type STS_NO_IDS    = 3'd4;

   localparam slot_type LAST_SLOT = SLOT_BITS'(TABLE_ENTRIES - 1);
   localparam cnt_type  SCAN_END  = CNT_BITS'(TABLE_ENTRIES);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [31:0] tag_high;
      logic [63:0] tag_low;
      id_type      id;
      logic        present;
      thr_type     miss;
   } entry_type;

   typedef struct packed {
      logic      en;
      slot_type  addr;
      entry_type data;
   } mem_wr_type;

endpackage

// ===== hw/rtl/rtpt_entry_mem.sv =====
module rtpt_entry_mem
   import rtpt_pkg::*;
(
   input  logic       clock,
   input  slot_type   rd_addr,
   input  mem_wr_type wr,
   output entry_type  rd_data
);

   entry_type entry_ram [TABLE_ENTRIES];
   entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         entry_ram[wr.addr] <= wr.data;
      end
      rd_data_ff <= entry_ram[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/rfid_tag_presence_tracker_core.sv =====
// channel    ports                               handshake
// request    req_type, req_tag_*, req_remove_id  start & !busy
// response   rsp_*                               rsp_valid, one cycle, no back-pressure
// config     csr_wdata (missing_threshold)       csr_valid & csr_ready
//
// each known request walks every slot of the entry ram through its single read port,
// one slot a cycle: busy stays high from the accept until the finish state ends.
// a sweep emits change events while the walk runs, the last item follows the final slot.
// request codes 5 to 7 are dropped at the accept and give no item.
// synchronous reset clears valid and seen bits and sets the threshold to 3; no ram clear.
// results cannot be stalled, so the block never waits on the response side.
`include "rfid_tag_presence_tracker_core_defines.svh"

module rfid_tag_presence_tracker_core
   import rtpt_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [2:0]   req_type,
   input  logic [31:0]  req_tag_high,
   input  logic [63:0]  req_tag_low,
   input  logic [15:0]  req_remove_id,
   output logic         rsp_valid,
   output logic [1:0]   rsp_event_kind,
   output logic [2:0]   rsp_status,
   output logic [15:0]  rsp_entry_id,
   output logic [4:0]   rsp_entry_slot,
   output logic         rsp_tag_matched,
   output logic         rsp_last,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [7:0]   csr_wdata
);

   state_type state_ff, state_in;

   req_code_type req_type_ff, req_type_in;
   logic [31:0]  tag_high_ff, tag_high_in;
   logic [63:0]  tag_low_ff, tag_low_in;
   id_type       rid_ff, rid_in;
   thr_type      thr_ff, thr_in;

   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;
   logic [TABLE_ENTRIES-1:0] seen_ff, seen_in;

   cnt_type  issue_ff, issue_in;
   logic     chk_vld_ff, chk_vld_in;
   slot_type chk_slot_ff, chk_slot_in;

   logic     hit_fnd_ff, hit_fnd_in;
   slot_type hit_slot_ff, hit_slot_in;
   id_type   hit_id_ff, hit_id_in;
   logic     free_fnd_ff, free_fnd_in;
   slot_type free_slot_ff, free_slot_in;
   id_type   max_id_ff, max_id_in;

   logic         rsp_vld_ff, rsp_vld_in;
   evt_code_type rsp_kind_ff, rsp_kind_in;
   sts_code_type rsp_sts_ff, rsp_sts_in;
   id_type       rsp_id_ff, rsp_id_in;
   slot_type     rsp_slot_ff, rsp_slot_in;
   logic         rsp_match_ff, rsp_match_in;
   logic         rsp_last_ff, rsp_last_in;

   logic       accept;
   logic       req_known;
   slot_type   rd_addr;
   entry_type  rd_data;
   mem_wr_type mem_wr;

   logic    cur_valid, cur_seen, tag_eq, id_eq, match;
   logic    was_present, now_present;
   thr_type miss_new;
   id_type  next_id;

   rtpt_entry_mem u_entry_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .wr      (mem_wr),
      .rd_data (rd_data)
   );

   assign busy      = (state_ff != S_IDLE);
   assign accept    = start && !busy;
   assign req_known = (req_type <= REQ_DEL_TAG);
   assign csr_ready = 1'b1;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept && req_known) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (chk_vld_ff && chk_slot_ff == LAST_SLOT) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // per-slot compare and hysteresis on the entry just read back
   always_comb begin
      cur_valid = valid_ff[chk_slot_ff];
      cur_seen  = seen_ff[chk_slot_ff];
      tag_eq    = (rd_data.tag_high == tag_high_ff) && (rd_data.tag_low == tag_low_ff);
      id_eq     = (rd_data.id == rid_ff);
      match     = cur_valid && ((req_type_ff == REQ_DEL_ID) ? id_eq : tag_eq);

      was_present = rd_data.present;
      if (cur_seen) begin
         miss_new    = '0;
         now_present = 1'b1;
      end else begin
         miss_new    = (rd_data.miss < thr_ff) ? rd_data.miss + thr_type'(1) : rd_data.miss;
         now_present = was_present && (miss_new < thr_ff);
      end
      next_id = max_id_ff + id_type'(1);
   end

   // outputs and datapath next values
   always_comb begin
      req_type_in  = req_type_ff;
      tag_high_in  = tag_high_ff;
      tag_low_in   = tag_low_ff;
      rid_in       = rid_ff;
      thr_in       = thr_ff;
      valid_in     = valid_ff;
      seen_in      = seen_ff;
      issue_in     = issue_ff;
      chk_vld_in   = 1'b0;
      chk_slot_in  = issue_ff[SLOT_BITS-1:0];
      hit_fnd_in   = hit_fnd_ff;
      hit_slot_in  = hit_slot_ff;
      hit_id_in    = hit_id_ff;
      free_fnd_in  = free_fnd_ff;
      free_slot_in = free_slot_ff;
      max_id_in    = max_id_ff;
      rsp_vld_in   = 1'b0;
      rsp_kind_in  = EVT_ACK;
      rsp_sts_in   = STS_OK;
      rsp_id_in    = '0;
      rsp_slot_in  = '0;
      rsp_match_in = 1'b0;
      rsp_last_in  = 1'b0;
      rd_addr      = issue_ff[SLOT_BITS-1:0];
      mem_wr       = '{en: 1'b0, addr: chk_slot_ff, data: rd_data};

      if (csr_valid && csr_ready) begin
         thr_in = csr_wdata;
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               req_type_in = req_type;
               tag_high_in = req_tag_high;
               tag_low_in  = req_tag_low;
               rid_in      = req_remove_id;
               issue_in    = '0;
               hit_fnd_in  = 1'b0;
               free_fnd_in = 1'b0;
               max_id_in   = '0;
            end
         end
         S_SCAN: begin
            if (issue_ff != SCAN_END) begin
               chk_vld_in = 1'b1;
               issue_in   = issue_ff + cnt_type'(1);
            end
            if (chk_vld_ff) begin
               if (req_type_ff == REQ_SWEEP) begin
                  seen_in[chk_slot_ff] = 1'b0;
                  if (cur_valid) begin
                     mem_wr.en           = 1'b1;
                     mem_wr.data.present = now_present;
                     mem_wr.data.miss    = miss_new;
                     if (was_present != now_present) begin
                        rsp_vld_in  = 1'b1;
                        rsp_kind_in = was_present ? EVT_MISSING : EVT_FOUND;
                        rsp_id_in   = rd_data.id;
                        rsp_slot_in = chk_slot_ff;
                     end
                  end
               end else begin
                  // lowest matching slot wins
                  if (match && !hit_fnd_ff) begin
                     hit_fnd_in  = 1'b1;
                     hit_slot_in = chk_slot_ff;
                     hit_id_in   = rd_data.id;
                  end
                  if (!cur_valid && !free_fnd_ff) begin
                     free_fnd_in  = 1'b1;
                     free_slot_in = chk_slot_ff;
                  end
                  if (cur_valid && rd_data.id > max_id_ff) begin
                     max_id_in = rd_data.id;
                  end
               end
            end
         end
         S_FINISH: begin
            rsp_vld_in  = 1'b1;
            rsp_last_in = 1'b1;
            case (req_type_ff)
               REQ_READ: begin
                  rsp_match_in = hit_fnd_ff;
                  if (hit_fnd_ff) begin
                     rsp_slot_in          = hit_slot_ff;
                     seen_in[hit_slot_ff] = 1'b1;
                  end else begin
                     rsp_sts_in = STS_NOT_FOUND;
                  end
               end
               REQ_SWEEP: begin
                  rsp_kind_in = EVT_DONE;
               end
               REQ_ADD: begin
                  if (hit_fnd_ff) begin
                     rsp_sts_in  = STS_DUPLICATE;
                     rsp_slot_in = hit_slot_ff;
                  end else if (!free_fnd_ff) begin
                     rsp_sts_in = STS_FULL;
                  end else if (&max_id_ff) begin
                     rsp_sts_in = STS_NO_IDS;
                  end else begin
                     rsp_id_in               = next_id;
                     rsp_slot_in             = free_slot_ff;
                     valid_in[free_slot_ff]  = 1'b1;
                     seen_in[free_slot_ff]   = 1'b0;
                     mem_wr.en               = 1'b1;
                     mem_wr.addr             = free_slot_ff;
                     mem_wr.data.tag_high    = tag_high_ff;
                     mem_wr.data.tag_low     = tag_low_ff;
                     mem_wr.data.id          = next_id;
                     mem_wr.data.present     = 1'b1;
                     mem_wr.data.miss        = '0;
                  end
               end
               REQ_DEL_ID, REQ_DEL_TAG: begin
                  if (hit_fnd_ff) begin
                     rsp_id_in             = hit_id_ff;
                     rsp_slot_in           = hit_slot_ff;
                     valid_in[hit_slot_ff] = 1'b0;
                     seen_in[hit_slot_ff]  = 1'b0;
                  end else begin
                     rsp_sts_in = STS_NOT_FOUND;
                  end
               end
               default: begin
                  rsp_vld_in  = 1'b0;
                  rsp_last_in = 1'b0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         thr_ff     <= THR_RESET;
         valid_ff   <= '0;
         seen_ff    <= '0;
         issue_ff   <= '0;
         chk_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         thr_ff     <= thr_in;
         valid_ff   <= valid_in;
         seen_ff    <= seen_in;
         issue_ff   <= issue_in;
         chk_vld_ff <= chk_vld_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      req_type_ff  <= req_type_in;
      tag_high_ff  <= tag_high_in;
      tag_low_ff   <= tag_low_in;
      rid_ff       <= rid_in;
      chk_slot_ff  <= chk_slot_in;
      hit_fnd_ff   <= hit_fnd_in;
      hit_slot_ff  <= hit_slot_in;
      hit_id_ff    <= hit_id_in;
      free_fnd_ff  <= free_fnd_in;
      free_slot_ff <= free_slot_in;
      max_id_ff    <= max_id_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_sts_ff   <= rsp_sts_in;
      rsp_id_ff    <= rsp_id_in;
      rsp_slot_ff  <= rsp_slot_in;
      rsp_match_ff <= rsp_match_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid       = rsp_vld_ff;
   assign rsp_event_kind  = rsp_kind_ff;
   assign rsp_status      = rsp_sts_ff;
   assign rsp_entry_id    = rsp_id_ff;
   assign rsp_entry_slot  = rsp_slot_ff;
   assign rsp_tag_matched = rsp_match_ff;
   assign rsp_last        = rsp_last_ff;

   `RTPT_ASSERT_NEXT(a_known_req_busy, clock, reset, accept && req_known, busy)
   `RTPT_ASSERT_IMPL(a_last_item_idle, clock, reset, rsp_valid && rsp_last, state_ff == S_IDLE)
   `RTPT_ASSERT_IMPL(a_chk_in_scan, clock, reset, chk_vld_ff, state_ff == S_SCAN)
   `RTPT_ASSERT_IMPL(a_event_in_walk, clock, reset, rsp_valid && !rsp_last, state_ff != S_IDLE)

endmodule
